// File: rtl/core/sorted_set_delta_toggle_top_defines.svh
// Assertion macros shared by the RTL of the sorted set block.
`ifndef SORTED_SET_DELTA_TOGGLE_TOP_DEFINES_SVH
`define SORTED_SET_DELTA_TOGGLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked while in reset.
`define SSDT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and masked while in reset.
`define SSDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ssdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssdt_pkg;
	localparam int KEY_W = 31;
	localparam int BASE_DEPTH_DEF = 1024;
	localparam int DELTA_DEPTH_DEF = 64;

	localparam logic [2:0] OP_CHECK  = 3'd0;
	localparam logic [2:0] OP_TOGGLE = 3'd1;
	localparam logic [2:0] OP_APPEND = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_MERGE  = 3'd4;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SET   = 3'd1;
	localparam logic [2:0] ST_UNSET = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_TRUNC = 3'd4;
endpackage
`default_nettype wire

// File: rtl/core/sorted_set_delta_toggle_top.sv
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: busy is high from acceptance until the cycle of the done strobe.
// A check runs a binary search of the base table and then of the delta table, each step a
// registered read of a table memory and then a compare; a toggle adds a read and a write per
// shifted delta entry, and a merge a read and a copy per merge step and per copied key.
// Results cannot be stalled. Reset clears the counts and the controller, not the tables.
module sorted_set_delta_toggle_top import ssdt_pkg::*; #(
	parameter int BASE_DEPTH = BASE_DEPTH_DEF,
	parameter int DELTA_DEPTH = DELTA_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [2:0]       opcode,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic             want_set,
	output logic                  done,
	output logic                  member,
	output logic      [2:0]       status
);
	`include "sorted_set_delta_toggle_top_defines.svh"

	localparam int BAW = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
	localparam int DAW = (DELTA_DEPTH > 1) ? $clog2(DELTA_DEPTH) : 1;
	localparam int BCW = $clog2(BASE_DEPTH + 1);
	localparam int DCW = $clog2(DELTA_DEPTH + 1);
	localparam int SW = (BCW > DCW) ? BCW : DCW;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_SRCH = 13'b0000000000010,
		S_SCMP = 13'b0000000000100,
		S_APPC = 13'b0000000001000,
		S_RMRD = 13'b0000000010000,
		S_RMWR = 13'b0000000100000,
		S_INRD = 13'b0000001000000,
		S_INWR = 13'b0000010000000,
		S_MGRD = 13'b0000100000000,
		S_MGCP = 13'b0001000000000,
		S_CPRD = 13'b0010000000000,
		S_CPWR = 13'b0100000000000,
		S_FIN  = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		PH_B1 = 2'd0,
		PH_D1 = 2'd1,
		PH_B2 = 2'd2
	} phase_t;

	state_t state_q;
	phase_t ph_q;
	logic [2:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic want_q, hit_q, hb_q, lost_q, forced_q, member_q;
	logic [2:0] status_q;
	logic [SW-1:0] lo_q, hi_q, idx_q, mid;
	logic [DCW-1:0] pos_q, dc_q, mj_q;
	logic [BCW-1:0] bc_q, mi_q, mk_q;

	logic b_we, d_we, m_we;
	logic [BAW-1:0] b_waddr, b_raddr, m_waddr, m_raddr;
	logic [DAW-1:0] d_waddr, d_raddr;
	logic [KEY_W-1:0] b_wdata, d_wdata, m_wdata, b_rdata, d_rdata, m_rdata, s_rdata;
	logic cur;

	ssdt_ram #(.DEPTH(BASE_DEPTH), .AW(BAW)) u_base (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);
	ssdt_ram #(.DEPTH(DELTA_DEPTH), .AW(DAW)) u_delta (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);
	ssdt_ram #(.DEPTH(BASE_DEPTH), .AW(BAW)) u_merge (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign s_rdata = (ph_q == PH_D1) ? d_rdata : b_rdata;
	assign cur = hb_q ^ hit_q;
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);
	assign member = member_q;
	assign status = status_q;

	always_comb begin
		b_we = 1'b0;
		b_waddr = '0;
		b_wdata = key_q;
		b_raddr = '0;
		d_we = 1'b0;
		d_waddr = '0;
		d_wdata = key_q;
		d_raddr = '0;
		m_we = 1'b0;
		m_waddr = mk_q[BAW-1:0];
		m_wdata = d_rdata;
		m_raddr = idx_q[BAW-1:0];
		unique case (state_q)
			S_IDLE: begin
				b_raddr = BAW'(bc_q - BCW'(1));
				if (start && opcode == OP_APPEND && bc_q == '0) begin
					b_we = 1'b1;
					b_wdata = key;
				end
			end
			S_SRCH: begin
				b_raddr = mid[BAW-1:0];
				d_raddr = mid[DAW-1:0];
				if (lo_q >= hi_q && ph_q == PH_D1 && op_q == OP_TOGGLE && cur != want_q
						&& !hit_q && dc_q < DCW'(DELTA_DEPTH)) begin
					if (SW'(dc_q) == lo_q) begin
						d_we = 1'b1;
						d_waddr = lo_q[DAW-1:0];
					end
				end
			end
			S_APPC: begin
				if (key_q > b_rdata) begin
					b_we = 1'b1;
					b_waddr = bc_q[BAW-1:0];
				end
			end
			S_RMRD: d_raddr = DAW'(idx_q + SW'(1));
			S_RMWR: begin
				d_we = 1'b1;
				d_waddr = idx_q[DAW-1:0];
				d_wdata = d_rdata;
			end
			S_INRD: begin
				d_raddr = DAW'(idx_q - SW'(1));
				if (idx_q <= SW'(pos_q)) begin
					d_we = 1'b1;
					d_waddr = pos_q[DAW-1:0];
				end
			end
			S_INWR: begin
				d_we = 1'b1;
				d_waddr = idx_q[DAW-1:0];
				d_wdata = d_rdata;
			end
			S_MGRD: begin
				b_raddr = mi_q[BAW-1:0];
				d_raddr = mj_q[DAW-1:0];
			end
			S_MGCP: begin
				if ((mi_q < bc_q) && (mj_q < dc_q) && b_rdata == d_rdata) begin
					m_we = 1'b0;
				end else if ((mi_q < bc_q) && (!(mj_q < dc_q) || b_rdata < d_rdata)) begin
					m_we = 1'b1;
					m_wdata = b_rdata;
				end else begin
					m_we = 1'b1;
				end
			end
			S_CPRD: begin
				if (!(idx_q < SW'(mk_q)) && forced_q) begin
					d_we = 1'b1;
				end
			end
			S_CPWR: begin
				b_we = 1'b1;
				b_waddr = idx_q[BAW-1:0];
				b_wdata = m_rdata;
			end
			S_FIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= PH_B1;
			bc_q <= '0;
			dc_q <= '0;
			member_q <= 1'b0;
			status_q <= ST_OK;
			forced_q <= 1'b0;
			lost_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= opcode;
						key_q <= key;
						want_q <= want_set;
						member_q <= 1'b0;
						status_q <= (opcode == OP_APPEND && bc_q >= BCW'(BASE_DEPTH))
							? ST_FULL : ST_OK;
						forced_q <= 1'b0;
						lost_q <= 1'b0;
						if (opcode == OP_CHECK || opcode == OP_TOGGLE) begin
							lo_q <= '0;
							hi_q <= SW'(bc_q);
							hit_q <= 1'b0;
							ph_q <= PH_B1;
							state_q <= S_SRCH;
						end else if (opcode == OP_APPEND) begin
							if (bc_q >= BCW'(BASE_DEPTH)) begin
								state_q <= S_FIN;
							end else if (bc_q == '0) begin
								bc_q <= BCW'(1);
								state_q <= S_FIN;
							end else begin
								state_q <= S_APPC;
							end
						end else if (opcode == OP_CLEAR) begin
							bc_q <= '0;
							state_q <= S_FIN;
						end else if (opcode == OP_MERGE && dc_q != '0) begin
							mi_q <= '0;
							mj_q <= '0;
							mk_q <= '0;
							state_q <= S_MGRD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_SCMP;
					end else begin
						unique case (ph_q)
							PH_B1: begin
								hb_q <= hit_q;
								lo_q <= '0;
								hi_q <= SW'(dc_q);
								hit_q <= 1'b0;
								ph_q <= PH_D1;
							end
							PH_D1: begin
								pos_q <= DCW'(lo_q);
								if (op_q == OP_TOGGLE && cur != want_q) begin
									member_q <= want_q;
									if (hit_q) begin
										idx_q <= lo_q;
										state_q <= S_RMRD;
									end else if (dc_q >= DCW'(DELTA_DEPTH)) begin
										forced_q <= 1'b1;
										mi_q <= '0;
										mj_q <= '0;
										mk_q <= '0;
										state_q <= S_MGRD;
									end else if (SW'(dc_q) == lo_q) begin
										dc_q <= dc_q + DCW'(1);
										status_q <= ST_SET;
										state_q <= S_FIN;
									end else begin
										idx_q <= SW'(dc_q);
										state_q <= S_INRD;
									end
								end else begin
									member_q <= cur;
									state_q <= S_FIN;
								end
							end
							PH_B2: begin
								member_q <= !hit_q;
								status_q <= lost_q ? ST_TRUNC : ST_SET;
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_SCMP: begin
					if (s_rdata < key_q) begin
						lo_q <= mid + SW'(1);
					end else begin
						hi_q <= mid;
						hit_q <= (s_rdata == key_q);
					end
					state_q <= S_SRCH;
				end
				S_APPC: begin
					if (key_q > b_rdata) begin
						bc_q <= bc_q + BCW'(1);
					end
					state_q <= S_FIN;
				end
				S_RMRD: begin
					if ((idx_q + SW'(1)) < SW'(dc_q)) begin
						state_q <= S_RMWR;
					end else begin
						dc_q <= dc_q - DCW'(1);
						status_q <= ST_UNSET;
						state_q <= S_FIN;
					end
				end
				S_RMWR: begin
					idx_q <= idx_q + SW'(1);
					state_q <= S_RMRD;
				end
				S_INRD: begin
					if (idx_q > SW'(pos_q)) begin
						state_q <= S_INWR;
					end else begin
						dc_q <= dc_q + DCW'(1);
						status_q <= ST_SET;
						state_q <= S_FIN;
					end
				end
				S_INWR: begin
					idx_q <= idx_q - SW'(1);
					state_q <= S_INRD;
				end
				S_MGRD: begin
					if (mk_q < BCW'(BASE_DEPTH) && ((mi_q < bc_q) || (mj_q < dc_q))) begin
						state_q <= S_MGCP;
					end else begin
						lost_q <= (mi_q < bc_q) || (mj_q < dc_q);
						idx_q <= '0;
						state_q <= S_CPRD;
					end
				end
				S_MGCP: begin
					if ((mi_q < bc_q) && (mj_q < dc_q) && b_rdata == d_rdata) begin
						mi_q <= mi_q + BCW'(1);
						mj_q <= mj_q + DCW'(1);
					end else if ((mi_q < bc_q) && (!(mj_q < dc_q) || b_rdata < d_rdata)) begin
						mi_q <= mi_q + BCW'(1);
						mk_q <= mk_q + BCW'(1);
					end else begin
						mj_q <= mj_q + DCW'(1);
						mk_q <= mk_q + BCW'(1);
					end
					state_q <= S_MGRD;
				end
				S_CPRD: begin
					if (idx_q < SW'(mk_q)) begin
						state_q <= S_CPWR;
					end else begin
						bc_q <= mk_q;
						if (forced_q) begin
							dc_q <= DCW'(1);
							lo_q <= '0;
							hi_q <= SW'(mk_q);
							hit_q <= 1'b0;
							ph_q <= PH_B2;
							state_q <= S_SRCH;
						end else begin
							dc_q <= '0;
							status_q <= lost_q ? ST_TRUNC : ST_OK;
							state_q <= S_FIN;
						end
					end
				end
				S_CPWR: begin
					idx_q <= idx_q + SW'(1);
					state_q <= S_CPRD;
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SSDT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`SSDT_ASSERT_NOW(a_done_busy, done, busy, "done strobe outside a request")
	`SSDT_ASSERT_NOW(a_delta_bound, 1'b1, dc_q <= DCW'(DELTA_DEPTH), "delta count overflow")
	`SSDT_ASSERT_NOW(a_base_bound, 1'b1, bc_q <= BCW'(BASE_DEPTH), "base count overflow")
	`SSDT_ASSERT_NOW(a_status_code, done, status <= ST_TRUNC, "undefined status code")
endmodule
`default_nettype wire

// File: rtl/core/ssdt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ssdt_ram import ssdt_pkg::*; #(
	parameter int DEPTH = BASE_DEPTH_DEF,
	parameter int AW = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [KEY_W-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [KEY_W-1:0] rdata
);
	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
